// ===== sv/owsrch_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owsrch_pkg
// Shared types and constants for the 1-Wire search ROM engine.
// ---------------------------------------------------------------------------
package owsrch_pkg;

  // ROM number width and width of the bit position counter
  localparam int RomWidth = 64;
  localparam int PosWidth = 7;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BIT     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_FAMILY  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_WRITE_DIR   = 3'd0,
    ST_FOUND       = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_STARTED     = 3'd3,
    ST_ACK         = 3'd4,
    ST_BIT_OUTSIDE = 3'd5
  } status_t;

  // Search state held between items
  typedef struct packed {
    logic [RomWidth-1:0] rom_bits;
    logic [PosWidth-1:0] last_discrepancy;
    logic                last_device_flag;
    logic [PosWidth-1:0] bit_position;
    logic [PosWidth-1:0] last_zero_position;
    logic                searching;
  } search_state_t;

endpackage

// ===== sv/owsrch_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owsrch_req_if
// Request channel of the search engine: one command item per transfer.
// ---------------------------------------------------------------------------
interface owsrch_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       presence;
  logic       id_bit;
  logic       comp_bit;
  logic [7:0] family_byte;

  modport source (output valid, cmd, presence, id_bit, comp_bit, family_byte,
                  input ready);
  modport sink (input valid, cmd, presence, id_bit, comp_bit, family_byte,
                output ready);
endinterface

// ===== sv/owsrch_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owsrch_rsp_if
// Response channel of the search engine: one result item per transfer.
// ---------------------------------------------------------------------------
interface owsrch_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        direction;
  logic [63:0] rom_code;
  logic        last_device;

  modport source (output valid, status, direction, rom_code, last_device,
                  input ready);
  modport sink (input valid, status, direction, rom_code, last_device,
                output ready);
endinterface

// ===== sv/onewire_rom_search_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// onewire_rom_search_engine
// Search ROM engine: picks the write direction for each observed bit pair
// and assembles the 64-bit ROM number over successive search passes.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: start (with the presence bit of
//   the bus reset), an observed id/complement bit pair, restart, or a target
//   family preset. rsp returns exactly one result per request: the status,
//   the direction bit to write on the bus, the ROM number when a pass ends,
//   and the last-device flag.
//   A transferred request has its result in the output register in the
//   cycle after the transfer. Throughput is one request per cycle while rsp
//   is not stalled; the search state update and the result are formed in a
//   single pass of logic between the request port and the result register.
//   While rsp is stalled with a result held, req.ready drops; it rises in
//   the same cycle the held result is transferred.
//   Reset clears the ROM number and discrepancy counters, sets the bit
//   position to one, closes any pass and empties the output register.
// ---------------------------------------------------------------------------
module onewire_rom_search_engine (
  input  logic                clk,
  input  logic                rst,
  owsrch_req_if.sink          req,
  owsrch_rsp_if.source        rsp
);

  localparam int RomWidth = owsrch_pkg::RomWidth;
  localparam int PosWidth = owsrch_pkg::PosWidth;
  localparam int ShWidth  = $clog2(RomWidth);

  owsrch_pkg::search_state_t st;
  owsrch_pkg::search_state_t st_next;

  logic                 rsp_valid;
  owsrch_pkg::status_t  rsp_status;
  logic                 rsp_direction;
  logic [RomWidth-1:0]  rsp_rom_code;
  logic                 rsp_last_device;

  owsrch_pkg::status_t  status_next;
  logic                 dir_next;
  logic [RomWidth-1:0]  rom_out_next;

  owsrch_pkg::cmd_t     cmd;
  logic                 req_fire;
  logic [PosWidth-1:0]  pos;
  logic [ShWidth-1:0]   sh;

  // Accept a request whenever the output register is free or being drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign cmd       = owsrch_pkg::cmd_t'(req.cmd);
  assign pos       = st.bit_position;
  assign sh        = pos[ShWidth-1:0] - ShWidth'(1);

  // Next search state and result for the request at the port
  always_comb begin
    st_next      = st;
    status_next  = owsrch_pkg::ST_ACK;
    dir_next     = 1'b0;
    rom_out_next = '0;
    case (cmd)
      owsrch_pkg::CMD_START: begin
        st_next.bit_position       = PosWidth'(1);
        st_next.last_zero_position = '0;
        if (st.last_device_flag || !req.presence) begin
          // no pass opens: clear counters and report end
          st_next.searching        = 1'b0;
          st_next.last_discrepancy = '0;
          st_next.last_device_flag = 1'b0;
          status_next              = owsrch_pkg::ST_NOT_FOUND;
          rom_out_next             = st.rom_bits;
        end else begin
          st_next.searching = 1'b1;
          status_next       = owsrch_pkg::ST_STARTED;
        end
      end
      owsrch_pkg::CMD_BIT: begin
        if (!st.searching) begin
          status_next = owsrch_pkg::ST_BIT_OUTSIDE;
        end else if (req.id_bit && req.comp_bit) begin
          // no device answered: drop the pass
          st_next.searching          = 1'b0;
          st_next.bit_position       = PosWidth'(1);
          st_next.last_zero_position = '0;
          st_next.last_discrepancy   = '0;
          st_next.last_device_flag   = 1'b0;
          status_next                = owsrch_pkg::ST_NOT_FOUND;
          rom_out_next               = st.rom_bits;
        end else begin
          // pick the direction: forced bit, or discrepancy rule
          if (req.id_bit != req.comp_bit) begin
            dir_next = req.id_bit;
          end else if (pos < st.last_discrepancy) begin
            dir_next = st.rom_bits[sh];
          end else begin
            dir_next = (pos == st.last_discrepancy);
          end
          if (req.id_bit == req.comp_bit && !dir_next) begin
            st_next.last_zero_position = pos;
          end
          st_next.rom_bits[sh] = dir_next;

          if (pos >= PosWidth'(RomWidth)) begin
            // last bit: close the pass and report the ROM number
            st_next.last_discrepancy = st_next.last_zero_position;
            if (st_next.last_zero_position == '0) begin
              st_next.last_device_flag = 1'b1;
            end
            if (st_next.rom_bits[7:0] == 8'd0) begin
              st_next.last_discrepancy = '0;
              st_next.last_device_flag = 1'b0;
              status_next              = owsrch_pkg::ST_NOT_FOUND;
            end else begin
              status_next = owsrch_pkg::ST_FOUND;
            end
            rom_out_next               = st_next.rom_bits;
            st_next.searching          = 1'b0;
            st_next.bit_position       = PosWidth'(1);
            st_next.last_zero_position = '0;
          end else begin
            st_next.bit_position = pos + PosWidth'(1);
            status_next          = owsrch_pkg::ST_WRITE_DIR;
          end
        end
      end
      owsrch_pkg::CMD_RESTART: begin
        st_next.rom_bits           = '0;
        st_next.last_discrepancy   = '0;
        st_next.last_device_flag   = 1'b0;
        st_next.searching          = 1'b0;
        st_next.bit_position       = PosWidth'(1);
        st_next.last_zero_position = '0;
      end
      owsrch_pkg::CMD_FAMILY: begin
        st_next.rom_bits           = {{(RomWidth-8){1'b0}}, req.family_byte};
        st_next.last_discrepancy   = PosWidth'(RomWidth);
        st_next.last_device_flag   = 1'b0;
        st_next.searching          = 1'b0;
        st_next.bit_position       = PosWidth'(1);
        st_next.last_zero_position = '0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // Search state register: advance on each request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st.rom_bits           <= '0;
      st.last_discrepancy   <= '0;
      st.last_device_flag   <= 1'b0;
      st.bit_position       <= PosWidth'(1);
      st.last_zero_position <= '0;
      st.searching          <= 1'b0;
    end else if (req_fire) begin
      st <= st_next;
    end
  end

  // Output register valid: load on request, drop on response transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_status      <= status_next;
      rsp_direction   <= dir_next;
      rsp_rom_code    <= rom_out_next;
      rsp_last_device <= st_next.last_device_flag;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.direction   = rsp_direction;
  assign rsp.rom_code    = rsp_rom_code;
  assign rsp.last_device = rsp_last_device;

`ifndef ASSERT_OFF
  // a start without presence never opens a pass
  a_start_no_presence: assert property (@(posedge clk) disable iff (rst)
    req_fire && cmd == owsrch_pkg::CMD_START && !req.presence
    |=> !st.searching && rsp.valid && rsp.status == owsrch_pkg::ST_NOT_FOUND)
    else $error("start without presence opened a pass");

  // outside a pass the bit counter rests at one
  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    !st.searching |-> st.bit_position == PosWidth'(1))
    else $error("bit position not at one outside a pass");

  // a held result blocks new requests
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while result held");

  // each request transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp.valid)
    else $error("result missing after request transfer");
`endif

endmodule
